@@ src/mrb_pkg.sv @@
// Shared constants, codes and control types for the multi ring buffer block.
// Used by every file under src except mrb_ram; depends on nothing.
package mrb_pkg;

   localparam int MAX_BUFFERS = 4;
   localparam int MAX_DEPTH   = 64;
   localparam int ALPHABET    = 256;

   // field widths fixed by the interface
   localparam int BN_W       = 8;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int FILL_W     = 7;
   localparam int COUNT_W    = 16;
   localparam int IN_USE_W   = 3;
   localparam int CAP_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam int NUM_CAP_REGS = 4;
   localparam int CAP_RESET    = 64;

   localparam int BUF_W     = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam int PTR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int SYM_W     = $clog2(ALPHABET);
   localparam int RING_AW   = BUF_W + PTR_W;
   localparam int HIST_AW   = BUF_W + SYM_W;
   localparam int RING_SIZE = 1 << RING_AW;
   localparam int HIST_SIZE = 1 << HIST_AW;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED  = 2'd0,
      ST_NO_BUF  = 2'd1,
      ST_BAD_NUM = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFERS_IN_USE = 3'd0,
      CSR_CAP_A          = 3'd1,
      CSR_CAP_B          = 3'd2,
      CSR_CAP_C          = 3'd3,
      CSR_CAP_D          = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_UPDATE,
      S_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic latch;     // capture request payload
      logic lookup;    // memory reads in flight, error result staged
      logic update;    // memory writes, pointer and fill update
      logic clear;     // histogram clearing pass step
      logic load_out;  // staged result into output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic err;
      logic clear_last;
   } dp_status_type;

endpackage

@@ src/mrb_if.sv @@
// Valid/ready channel interfaces: request, response and register write port.
// Depends on mrb_pkg for field widths.
interface mrb_req_if;
   logic                      valid;
   logic                      ready;
   logic [mrb_pkg::BN_W-1:0]   buffer_number;
   logic [mrb_pkg::BYTE_W-1:0] data_byte;
   modport source (output valid, buffer_number, data_byte, input ready);
   modport sink   (input valid, buffer_number, data_byte, output ready);
endinterface

interface mrb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mrb_pkg::STATUS_W-1:0] status;
   logic                        overwrote;
   logic [mrb_pkg::BYTE_W-1:0]   dropped_byte;
   logic [mrb_pkg::FILL_W-1:0]   fill_level;
   logic [mrb_pkg::COUNT_W-1:0]  occurrence_count;
   modport source (output valid, status, overwrote, dropped_byte, fill_level,
                   occurrence_count, input ready);
   modport sink   (input valid, status, overwrote, dropped_byte, fill_level,
                   occurrence_count, output ready);
endinterface

interface mrb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mrb_pkg::CSR_IDX_W-1:0]  index;
   logic [mrb_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/mrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/mrb_ctrl.sv @@
// Sequencer for the multi ring buffer: clearing pass, item steps, output handshake.
// Depends on mrb_pkg.
module mrb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mrb_pkg::dp_status_type sts,
   output mrb_pkg::ctrl_cmd_type  cmd
);

   mrb_pkg::fsm_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrb_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         mrb_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = mrb_pkg::S_IDLE;
            end
         end
         mrb_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = mrb_pkg::S_LOOKUP;
            end
         end
         mrb_pkg::S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = sts.err ? mrb_pkg::S_EMIT : mrb_pkg::S_UPDATE;
         end
         mrb_pkg::S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = mrb_pkg::S_EMIT;
         end
         mrb_pkg::S_EMIT: begin
            // output register free, or being emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mrb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mrb_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/mrb_dp.sv @@
// Datapath: config registers, per-buffer pointers and fill counts, ring and
// histogram memories, result staging and output register. Uses mrb_pkg, mrb_ram.
module mrb_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  mrb_pkg::ctrl_cmd_type             cmd,
   output mrb_pkg::dp_status_type            sts,
   input  logic [mrb_pkg::BN_W-1:0]          req_buffer_number,
   input  logic [mrb_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                              csr_we,
   input  logic [mrb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mrb_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [mrb_pkg::STATUS_W-1:0]      rsp_status,
   output logic                              rsp_overwrote,
   output logic [mrb_pkg::BYTE_W-1:0]        rsp_dropped_byte,
   output logic [mrb_pkg::FILL_W-1:0]        rsp_fill_level,
   output logic [mrb_pkg::COUNT_W-1:0]       rsp_occurrence_count
);

   // configuration
   logic [mrb_pkg::IN_USE_W-1:0] in_use_ff;
   logic [mrb_pkg::CAP_W-1:0]    cap_ff [mrb_pkg::NUM_CAP_REGS];

   // per-buffer state
   logic [mrb_pkg::PTR_W-1:0]  wp_ff   [mrb_pkg::MAX_BUFFERS];
   logic [mrb_pkg::PTR_W-1:0]  rp_ff   [mrb_pkg::MAX_BUFFERS];
   logic [mrb_pkg::FILL_W-1:0] fill_ff [mrb_pkg::MAX_BUFFERS];

   logic [mrb_pkg::HIST_AW-1:0] clr_cnt_ff;
   logic [mrb_pkg::BN_W-1:0]    num_ff;
   logic [mrb_pkg::BYTE_W-1:0]  byte_ff;

   // staged result and output register
   mrb_pkg::status_type          res_status_ff, out_status_ff;
   logic                         res_ovw_ff, out_ovw_ff;
   logic [mrb_pkg::BYTE_W-1:0]   res_drop_ff, out_drop_ff;
   logic [mrb_pkg::FILL_W-1:0]   res_fill_ff, out_fill_ff;
   logic [mrb_pkg::COUNT_W-1:0]  res_count_ff, out_count_ff;

   logic [mrb_pkg::IN_USE_W-1:0] in_use_cl;
   logic                         err_no_buf, err_bad_num;
   logic [mrb_pkg::BUF_W-1:0]    b;
   logic [mrb_pkg::CAP_W-1:0]    cap_raw, cap;
   logic [mrb_pkg::PTR_W-1:0]    wp, rp, wp_next, rp_next;
   logic [mrb_pkg::FILL_W-1:0]   fill;
   logic                         full;
   logic [mrb_pkg::BYTE_W-1:0]   ring_rdata;
   logic [mrb_pkg::COUNT_W-1:0]  hist_rdata, hist_new;
   logic                         hist_we;
   logic [mrb_pkg::HIST_AW-1:0]  hist_waddr, hist_addr;
   logic [mrb_pkg::COUNT_W-1:0]  hist_wdata;

   always_comb begin
      in_use_cl = (32'(in_use_ff) > mrb_pkg::MAX_BUFFERS) ?
                  (mrb_pkg::IN_USE_W)'(mrb_pkg::MAX_BUFFERS) : in_use_ff;
      err_no_buf  = (in_use_cl == '0);
      err_bad_num = (num_ff == '0) || (num_ff > (mrb_pkg::BN_W)'(in_use_cl));
      b = (mrb_pkg::BUF_W)'(num_ff - (mrb_pkg::BN_W)'(1));

      // buffers without a capacity register run at full depth
      cap_raw = (mrb_pkg::CAP_W)'(mrb_pkg::MAX_DEPTH);
      for (int i = 0; i < mrb_pkg::NUM_CAP_REGS; i++) begin
         if (32'(b) == i) begin
            cap_raw = cap_ff[i];
         end
      end
      if (cap_raw == '0) begin
         cap = (mrb_pkg::CAP_W)'(1);
      end else if (32'(cap_raw) > mrb_pkg::MAX_DEPTH) begin
         cap = (mrb_pkg::CAP_W)'(mrb_pkg::MAX_DEPTH);
      end else begin
         cap = cap_raw;
      end

      wp   = wp_ff[b];
      rp   = rp_ff[b];
      fill = fill_ff[b];
      full = (32'(fill) >= 32'(cap));
      wp_next = (32'(wp) + 32'd1 >= 32'(cap)) ? '0 :
                (mrb_pkg::PTR_W)'(wp + (mrb_pkg::PTR_W)'(1));
      rp_next = (32'(rp) + 32'd1 >= 32'(cap)) ? '0 :
                (mrb_pkg::PTR_W)'(rp + (mrb_pkg::PTR_W)'(1));

      hist_addr = {b, byte_ff};
      hist_new  = (hist_rdata == '1) ? hist_rdata :
                  (mrb_pkg::COUNT_W)'(hist_rdata + (mrb_pkg::COUNT_W)'(1));

      hist_we    = cmd.clear || cmd.update;
      hist_waddr = cmd.clear ? clr_cnt_ff : hist_addr;
      hist_wdata = cmd.clear ? '0 : hist_new;

      sts.err        = err_no_buf || err_bad_num;
      sts.clear_last = (clr_cnt_ff == '1);
   end

   mrb_ram #(.WIDTH(mrb_pkg::BYTE_W), .DEPTH(mrb_pkg::RING_SIZE)) u_ring (
      .clock (clock),
      .we    (cmd.update),
      .waddr ((mrb_pkg::RING_AW)'({b, wp})),
      .wdata (byte_ff),
      .raddr ((mrb_pkg::RING_AW)'({b, rp})),
      .rdata (ring_rdata)
   );

   mrb_ram #(.WIDTH(mrb_pkg::COUNT_W), .DEPTH(mrb_pkg::HIST_SIZE)) u_hist (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (hist_addr),
      .rdata (hist_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         clr_cnt_ff <= '0;
         for (int i = 0; i < mrb_pkg::NUM_CAP_REGS; i++) begin
            cap_ff[i] <= (mrb_pkg::CAP_W)'(mrb_pkg::CAP_RESET);
         end
         for (int i = 0; i < mrb_pkg::MAX_BUFFERS; i++) begin
            wp_ff[i]   <= '0;
            rp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               mrb_pkg::CSR_BUFFERS_IN_USE: in_use_ff <= csr_data[mrb_pkg::IN_USE_W-1:0];
               mrb_pkg::CSR_CAP_A:          cap_ff[0] <= csr_data[mrb_pkg::CAP_W-1:0];
               mrb_pkg::CSR_CAP_B:          cap_ff[1] <= csr_data[mrb_pkg::CAP_W-1:0];
               mrb_pkg::CSR_CAP_C:          cap_ff[2] <= csr_data[mrb_pkg::CAP_W-1:0];
               mrb_pkg::CSR_CAP_D:          cap_ff[3] <= csr_data[mrb_pkg::CAP_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clear) begin
            clr_cnt_ff <= (mrb_pkg::HIST_AW)'(clr_cnt_ff + (mrb_pkg::HIST_AW)'(1));
         end
         if (cmd.update) begin
            wp_ff[b] <= wp_next;
            if (full) begin
               rp_ff[b]   <= rp_next;
               fill_ff[b] <= (mrb_pkg::FILL_W)'(cap);
            end else begin
               fill_ff[b] <= (mrb_pkg::FILL_W)'(fill + (mrb_pkg::FILL_W)'(1));
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         num_ff  <= req_buffer_number;
         byte_ff <= req_data_byte;
      end
      if (cmd.lookup) begin
         res_status_ff <= err_no_buf ? mrb_pkg::ST_NO_BUF :
                          err_bad_num ? mrb_pkg::ST_BAD_NUM : mrb_pkg::ST_STORED;
         res_ovw_ff    <= 1'b0;
         res_drop_ff   <= '0;
         res_fill_ff   <= '0;
         res_count_ff  <= '0;
      end
      if (cmd.update) begin
         res_status_ff <= mrb_pkg::ST_STORED;
         res_ovw_ff    <= full;
         res_drop_ff   <= full ? ring_rdata : '0;
         res_fill_ff   <= full ? (mrb_pkg::FILL_W)'(cap) :
                          (mrb_pkg::FILL_W)'(fill + (mrb_pkg::FILL_W)'(1));
         res_count_ff  <= hist_new;
      end
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_ovw_ff    <= res_ovw_ff;
         out_drop_ff   <= res_drop_ff;
         out_fill_ff   <= res_fill_ff;
         out_count_ff  <= res_count_ff;
      end
   end

   assign rsp_status           = out_status_ff;
   assign rsp_overwrote        = out_ovw_ff;
   assign rsp_dropped_byte     = out_drop_ff;
   assign rsp_fill_level       = out_fill_ff;
   assign rsp_occurrence_count = out_count_ff;

endmodule

@@ src/multi_ring_buffer_with_char_histogram.sv @@
// Top level: several overwriting ring buffers with per-buffer byte histograms.
// Uses mrb_pkg, the channel interfaces, mrb_ctrl and mrb_dp.
//
// req carries a one-based buffer number and a byte. Each request yields one
// transfer on rsp: status, overwrite flag, dropped byte, fill level after the
// write, and the saturating count of that byte in the buffer's histogram.
// csr writes buffers_in_use (index 0) and the four capacities (indices 1-4);
// it is always ready, writes to other indices are ignored.
//
// Items are handled one at a time: accept, lookup (ring and histogram reads),
// update (writes), emit; an error item skips the update step. rsp.valid rises
// once emit has loaded the result into the output register. The update step
// waits on the registered read of both memories.
// The output register holds a result while rsp is stalled and req stays open
// for the next item; that item waits in emit until the register frees up.
//
// After reset the histogram memory is zeroed in a pass over its 1024 entries,
// one entry per cycle, with req.ready low. Ring contents are not cleared.
module multi_ring_buffer_with_char_histogram (
   input logic      clock,
   input logic      reset,
   mrb_req_if.sink   req,
   mrb_rsp_if.source rsp,
   mrb_csr_if.sink   csr
);

   mrb_pkg::ctrl_cmd_type  cmd;
   mrb_pkg::dp_status_type sts;

   assign csr.ready = 1'b1;

   mrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mrb_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_buffer_number    (req.buffer_number),
      .req_data_byte        (req.data_byte),
      .csr_we               (csr.valid & csr.ready),
      .csr_index            (csr.index),
      .csr_data             (csr.data),
      .rsp_status           (rsp.status),
      .rsp_overwrote        (rsp.overwrote),
      .rsp_dropped_byte     (rsp.dropped_byte),
      .rsp_fill_level       (rsp.fill_level),
      .rsp_occurrence_count (rsp.occurrence_count)
   );

endmodule
